>>> sv/brq_pkg.sv
// Package for the byte ring queue with preview.
// Shared widths, reset values, the operation code type and the result struct.
// No dependencies.
`default_nettype none

package brq_pkg;

  localparam int DEPTH_DEF = 256;  // default store depth
  localparam int CAP_W     = 9;    // capacity register and fill count width
  localparam int DATA_W    = 8;    // byte width
  localparam int MODE_W    = 2;    // operation code width

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH       = 2'd0,
    MODE_POP        = 2'd1,
    MODE_PEEK_START = 2'd2,
    MODE_PEEK_NEXT  = 2'd3
  } mode_t;

  // Everything of a result except the byte, which comes from the store.
  typedef struct packed {
    logic             data_valid;
    logic [CAP_W-1:0] fill_count;
    logic             overflow_flag;
  } brq_result_t;

endpackage

`default_nettype wire

>>> sv/brq_in_if.sv
// Input channel of the byte ring queue: valid/ready plus operation payload.
// Depends on brq_pkg for field widths.
`default_nettype none

interface brq_in_if;
  logic                        valid;
  logic                        ready;
  logic [brq_pkg::MODE_W-1:0]  mode;
  logic [brq_pkg::DATA_W-1:0]  push_byte;

  modport source (output valid, output mode, output push_byte, input ready);
  modport sink   (input valid, input mode, input push_byte, output ready);
endinterface

`default_nettype wire

>>> sv/brq_out_if.sv
// Result channel of the byte ring queue: valid/ready plus result payload.
// Depends on brq_pkg for field widths.
`default_nettype none

interface brq_out_if;
  logic                        valid;
  logic                        ready;
  logic [brq_pkg::DATA_W-1:0]  data_byte;
  logic                        data_valid;
  logic [brq_pkg::CAP_W-1:0]   fill_count;
  logic                        overflow_flag;

  modport source (output valid, output data_byte, output data_valid,
                  output fill_count, output overflow_flag, input ready);
  modport sink   (input valid, input data_byte, input data_valid,
                  input fill_count, input overflow_flag, output ready);
endinterface

`default_nettype wire

>>> sv/brq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/brq_ctrl.sv
// Pointer and count control of the byte ring queue: capacity register,
// store clearing sweep after reset, and the store access for each transaction.
// Depends on brq_pkg.
`default_nettype none

module brq_ctrl #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic [brq_pkg::MODE_W-1:0]     mode,
  input  wire logic [brq_pkg::DATA_W-1:0]     push_byte,
  input  wire logic                           cfg_we,
  input  wire logic [brq_pkg::CAP_W-1:0]      cfg_wdata,
  output      logic                           busy,
  output      logic                           mem_we,
  output      logic [$clog2(DEPTH)-1:0]       mem_waddr,
  output      logic [brq_pkg::DATA_W-1:0]     mem_wdata,
  output      logic                           mem_re,
  output      logic [$clog2(DEPTH)-1:0]       mem_raddr,
  output      brq_pkg::brq_result_t           res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = brq_pkg::CAP_W;
  localparam int SW = ((IW > CW) ? IW : CW) + 1;

  localparam logic [IW-1:0] LAST_ADDR = IW'(DEPTH - 1);

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i,
                                               input logic [CW-1:0] c);
    logic [SW-1:0] inc;
    inc = SW'(i) + SW'(1);
    return (inc >= SW'(c)) ? '0 : inc[IW-1:0];
  endfunction

  logic [CW-1:0] cap_r;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [IW-1:0] ri_r, ri_nxt;
  logic [IW-1:0] pi_r, pi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          clr_r;
  logic [IW-1:0] clr_addr_r;
  logic [CW-1:0] cap_eff;
  logic          dv;
  logic          rd;
  logic [IW-1:0] raddr;
  brq_pkg::mode_t op;

  // Zero capacity acts as one slot, anything above the store depth saturates.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (SW'(cap_r) > SW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign op = brq_pkg::mode_t'(mode);

  always_comb begin
    wi_nxt  = wi_r;
    ri_nxt  = ri_r;
    pi_nxt  = pi_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    dv      = 1'b0;
    rd      = 1'b0;
    raddr   = ri_r;
    unique case (op)
      brq_pkg::MODE_PUSH: begin
        if (cnt_r >= cap_eff) begin
          ri_nxt  = next_slot(ri_r, cap_eff);
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
        wi_nxt = next_slot(wi_r, cap_eff);
      end
      brq_pkg::MODE_POP: begin
        if (cnt_r != '0) begin
          rd      = 1'b1;
          dv      = 1'b1;
          raddr   = ri_r;
          ri_nxt  = next_slot(ri_r, cap_eff);
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      brq_pkg::MODE_PEEK_START: begin
        if (cnt_r != '0) begin
          rd     = 1'b1;
          dv     = 1'b1;
          raddr  = ri_r;
          pi_nxt = next_slot(ri_r, cap_eff);
        end
      end
      brq_pkg::MODE_PEEK_NEXT: begin
        if (cnt_r != '0) begin
          rd     = 1'b1;
          dv     = 1'b1;
          raddr  = pi_r;
          pi_nxt = next_slot(pi_r, cap_eff);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= brq_pkg::CAP_RESET;
      wi_r       <= '0;
      ri_r       <= '0;
      pi_r       <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + IW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_r <= 1'b0;
        end
      end
      // A capacity write empties the queue but keeps store and overflow flag.
      if (cfg_we) begin
        cap_r <= cfg_wdata;
        wi_r  <= '0;
        ri_r  <= '0;
        pi_r  <= '0;
        cnt_r <= '0;
      end else if (accept) begin
        wi_r  <= wi_nxt;
        ri_r  <= ri_nxt;
        pi_r  <= pi_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  assign busy      = clr_r;
  assign mem_we    = clr_r || (accept && (op == brq_pkg::MODE_PUSH));
  assign mem_waddr = clr_r ? clr_addr_r : wi_r;
  assign mem_wdata = clr_r ? '0 : push_byte;
  assign mem_re    = accept && rd;
  assign mem_raddr = raddr;

  assign res.data_valid    = dv;
  assign res.fill_count    = cnt_nxt;
  assign res.overflow_flag = ovf_nxt;

endmodule

`default_nettype wire

>>> sv/byte_ring_queue_with_preview.sv
// Top level of the byte ring queue with preview: handshakes, result pipeline.
// Depends on brq_pkg, brq_in_if, brq_out_if, brq_ctrl and brq_ram.
//
//   Channel  Direction  Handshake          Payload
//   in_ch    sink       valid/ready        mode, push_byte
//   out_ch   source     valid/ready        data_byte, data_valid, fill_count,
//                                          overflow_flag
//   cfg_*    sink       cfg_we (no ready)  cfg_wdata = capacity
//
// One transaction per cycle sustained while no sweep runs and out_ch is not
// stalled; each result passes the pending stage, then the output register. The
// store is read in the accept cycle; its read data register keeps the byte until
// it moves into the output register. After reset the store is cleared one entry
// per cycle, with in_ch.ready held low; capacity writes are taken during that
// sweep. A stalled output holds the pending stage and then drops in_ch.ready.
`default_nettype none

module byte_ring_queue_with_preview #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  brq_in_if.sink                         in_ch,
  brq_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [brq_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(DEPTH);

  logic                         busy;
  logic                         accept;
  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  logic [brq_pkg::DATA_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic [IW-1:0]                mem_raddr;
  logic [brq_pkg::DATA_W-1:0]   mem_rdata;
  brq_pkg::brq_result_t         res;

  // Pending stage: waits for the store read data.
  logic                         p_valid_r;
  brq_pkg::brq_result_t         p_res_r;
  logic                         p_move;

  // Output register.
  logic                         o_valid_r;
  logic [brq_pkg::DATA_W-1:0]   o_byte_r;
  brq_pkg::brq_result_t         o_res_r;

  // Advance the pending stage whenever the output register is free or drains.
  assign p_move      = p_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = !busy && (!p_valid_r || p_move);
  assign accept      = in_ch.valid && in_ch.ready;

  brq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_ch.mode),
    .push_byte (in_ch.push_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  // The read data register holds while no read is issued, so a stalled
  // pending stage keeps its byte.
  brq_ram #(
    .WIDTH (brq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res_r <= res;
    end
    if (p_move) begin
      o_res_r  <= p_res_r;
      // Push and empty-queue transactions report a zero byte.
      o_byte_r <= p_res_r.data_valid ? mem_rdata : '0;
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.data_byte     = o_byte_r;
  assign out_ch.data_valid    = o_res_r.data_valid;
  assign out_ch.fill_count    = o_res_r.fill_count;
  assign out_ch.overflow_flag = o_res_r.overflow_flag;

endmodule

`default_nettype wire

>>> test/ring_check_pkg.sv
// Result tracker for the byte ring queue testbench: mirrors the queue state,
// predicts the result of each operation and compares the results that arrive.
// Depends on brq_pkg.
package ring_check_pkg;
  import brq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              data_valid;
    logic [CAP_W-1:0]  fill_count;
    logic              overflow_flag;
  } queue_result_t;

  class ring_queue_tracker;
    logic [DATA_W-1:0] store_bytes [DEPTH_DEF];
    logic [7:0]        wr_ptr;
    logic [7:0]        rd_ptr;
    logic [7:0]        cursor;
    logic [CAP_W-1:0]  held;
    logic              overflowed;
    logic [CAP_W-1:0]  cap_reg;
    queue_result_t     pending_results [$];
    int unsigned       fault_count;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      cursor      = '0;
      held        = '0;
      overflowed  = 1'b0;
      cap_reg     = CAP_RESET;
      fault_count = 0;
    endfunction

    // Zero means one slot, anything past the store means the whole store.
    function int unsigned slots();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
      return cap_reg;
    endfunction

    function logic [7:0] advance(logic [7:0] slot, int unsigned c);
      if (int'(slot) + 1 >= c) return '0;
      return slot + 8'd1;
    endfunction

    // Empty the queue; keep the store contents and the overflow flag.
    function void set_capacity(logic [CAP_W-1:0] value);
      cap_reg = value;
      wr_ptr  = '0;
      rd_ptr  = '0;
      cursor  = '0;
      held    = '0;
    endfunction

    function void note_op(mode_t op, logic [DATA_W-1:0] value);
      int unsigned   c;
      queue_result_t r;
      c = slots();
      r = '0;
      if (op == MODE_PUSH) begin
        store_bytes[wr_ptr] = value;
        if (held >= c) begin
          rd_ptr     = advance(rd_ptr, c);
          overflowed = 1'b1;
        end else begin
          held = held + 1'b1;
        end
        wr_ptr = advance(wr_ptr, c);
      end else if (held != 0) begin
        if (op == MODE_POP) begin
          r.data_byte = store_bytes[rd_ptr];
          rd_ptr      = advance(rd_ptr, c);
          held        = held - 1'b1;
        end else begin
          if (op == MODE_PEEK_START) cursor = rd_ptr;
          r.data_byte = store_bytes[cursor];
          cursor      = advance(cursor, c);
        end
        r.data_valid = 1'b1;
      end
      r.fill_count    = held;
      r.overflow_flag = overflowed;
      pending_results.push_back(r);
    endfunction

    function void flag_field(string field, logic [CAP_W-1:0] want, logic [CAP_W-1:0] got);
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result with no operation outstanding: %0h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.data_byte !== want.data_byte)
        flag_field("data_byte", CAP_W'(want.data_byte), CAP_W'(got.data_byte));
      if (got.data_valid !== want.data_valid)
        flag_field("data_valid", CAP_W'(want.data_valid), CAP_W'(got.data_valid));
      if (got.fill_count !== want.fill_count)
        flag_field("fill_count", want.fill_count, got.fill_count);
      if (got.overflow_flag !== want.overflow_flag)
        flag_field("overflow_flag", CAP_W'(want.overflow_flag), CAP_W'(got.overflow_flag));
    endfunction
  endclass

endpackage

>>> test/testbench.sv
// Testbench top for byte_ring_queue_with_preview: drives push, pop and preview
// transactions under random idling and capacity changes, checks every result.
// Depends on brq_pkg, brq_in_if, brq_out_if, ring_check_pkg and the RTL.
module testbench;
  import brq_pkg::*;
  import ring_check_pkg::*;

  // Quiet cycles tolerated: covers the store sweep after reset, stall bursts
  // and the settle pauses around capacity writes, with a wide margin.
  localparam int WATCHDOG_LIMIT = 3000;
  // Pause added after every predicted result has been checked.
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASES         = 14;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  ring_queue_tracker tracker;

  brq_in_if  in_ch ();
  brq_out_if out_ch ();

  byte_ring_queue_with_preview uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check each accepted transaction, then pick the next ready.
  // Stall bursts of random length start only while stalls_on is set.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.check_result({out_ch.data_byte, out_ch.data_valid,
                            out_ch.fill_count, out_ch.overflow_flag});
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL byte_ring_queue_with_preview");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one operation, hold it until accepted, then record it.
  // Valid stays high into the next call unless that call opens a gap.
  task automatic send_op(input mode_t op, input logic [DATA_W-1:0] value);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= op;
    in_ch.push_byte <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_op(op, value);
  endtask

  // Drop valid and hold off until every predicted result has been checked.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity only while the queue pipeline is empty.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(value);
  endtask

  function automatic mode_t pick_op(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return MODE_PUSH;
    roll = $urandom_range(0, 2);
    if (roll == 0) return MODE_POP;
    if (roll == 1) return MODE_PEEK_START;
    return MODE_PEEK_NEXT;
  endfunction

  initial begin
    // Raw register values: zero, all ones and other values past the store
    // check the clamping; small capacities make wrap and overwrite common.
    int unsigned cap_plan [PHASES] = '{511, 2, 0, 7, 256, 1, 16, 300, 3, 255, 64, 5, 4, 9};
    int unsigned eff_cap;
    int unsigned len;
    int unsigned push_pct;
    bit          big;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_PUSH;
    in_ch.push_byte = '0;
    out_ch.ready    = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    tracker         = new();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset capacity: every read on the empty queue returns nothing, then
    // preview continue without a start begins at slot zero and runs past the
    // newest byte into stale store contents.
    send_op(MODE_POP, 8'($urandom));
    send_op(MODE_PEEK_START, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PUSH, 8'hFF);
    send_op(MODE_PUSH, 8'h00);
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PEEK_START, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));

    // Capacity zero acts as one slot: the second push overwrites the first.
    write_capacity(CAP_W'(0));
    send_op(MODE_PUSH, 8'hA5);
    send_op(MODE_PUSH, 8'h5A);
    send_op(MODE_PEEK_START, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));

    // Three slots: overwrite the oldest, then let the preview wrap around.
    write_capacity(CAP_W'(3));
    send_op(MODE_PUSH, 8'h01);
    send_op(MODE_PUSH, 8'h80);
    send_op(MODE_PUSH, 8'h7F);
    send_op(MODE_PUSH, 8'h55);
    send_op(MODE_PEEK_START, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_PEEK_NEXT, 8'($urandom));
    send_op(MODE_POP, 8'($urandom));

    // Random phases. Large capacities fill up with pushes first so that
    // overwrite is reached, then mix all operations on a full queue.
    // The last two phases run with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      eff_cap = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > DEPTH_DEF) ? DEPTH_DEF : cap_plan[p]);
      big     = (eff_cap >= 200);
      len     = big ? 320 : 50;
      write_capacity(CAP_W'(cap_plan[p]));
      gaps_on   = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);
      stalls_on = (p < PHASES - 2) && ($urandom_range(0, 2) != 0);
      push_pct  = $urandom_range(30, 80);
      for (int n = 0; n < len; n++) begin
        if (big) push_pct = (n < 260) ? 97 : 40;
        // Let the sender wait out every outstanding result once mid-phase.
        if (p == 4 && n == len / 2) wait_drained();
        send_op(pick_op(push_pct), 8'($urandom));
      end
    end

    wait_drained();
    if (tracker.fault_count == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS byte_ring_queue_with_preview");
    end else begin
      $display("FAIL byte_ring_queue_with_preview");
    end
    $finish;
  end

endmodule
